/* sv/acked_record_send_window_top_macros.svh */
`ifndef ACKED_RECORD_SEND_WINDOW_TOP_MACROS_SVH
`define ACKED_RECORD_SEND_WINDOW_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ARSW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication: when pre holds, post holds in the next cycle.
`define ARSW_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* sv/arsw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package arsw_pkg;

  localparam int unsigned ARSW_INDEX_BITS  = 10;
  localparam int unsigned ARSW_RECORD_BITS = 64;

  // fixed field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned DATA_W   = 64;
  localparam int unsigned ACK_W    = 10;
  localparam int unsigned START_W  = 10;
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned S_TDATA_W = 80;  // 64 + 10, padded to bytes
  localparam int unsigned M_TDATA_W = 80;  // 10 + 5 + 64, padded to bytes

  localparam logic [CNT_W-1:0] MAX_BATCH   = 5'd16;
  localparam logic [CNT_W-1:0] BLIM_RESET  = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEND   = 2'd1,
    OP_ACK    = 2'd2,
    OP_REWIND = 2'd3
  } arsw_op_e;

  typedef enum logic {
    KIND_HEADER = 1'b0,
    KIND_RECORD = 1'b1
  } arsw_kind_e;

  // controller -> datapath
  typedef struct packed {
    logic take;      // input transfer this cycle
    logic load_hdr;  // load batch header into output register
    logic load_rec;  // load current record into output register
  } arsw_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic send_nonempty;  // a send request now would emit a batch
    logic out_free;       // output register can take a new item
    logic rec_last;       // current record is the last of the batch
  } arsw_sts_t;

endpackage

`default_nettype wire

/* sv/acked_record_send_window_top.sv */
// Go-back-N send window: a ring of records with acked, send and write pointers.
// Input stream (s_axis): tuser carries the op (insert, send, ack, rewind),
// tdata carries the record payload and the ack index.
// Result stream (m_axis): a send request yields a header (tuser 0) with the
// start index and record count, then that many record words (tuser 1); tlast
// marks the final record word. Insert, ack and rewind yield nothing.
// Config channel: cfg_w* writes batch_limit (0 acts as 1, above 16 as 16).
// Flow: insert, ack, rewind and an empty send leave the controller idle with
// the input ready. A send of n records holds the input off while the header
// and then the records are loaded into the output register; one record per
// cycle follows while the result stream does not stall, set by the single
// read port of the record store (fetched one record ahead of the output
// register). The header is loaded in the header state that follows the
// request transfer, once the output register is free.
// While the result stream stalls, the output register holds its item and the
// batch sequencer waits; input is taken again once the batch is loaded.
// Reset: acked = 0, send = write = 1, batch_limit = 16, output empty. The
// record store is not cleared; no unwritten entry reaches the output.
`timescale 1ns / 1ps
`default_nettype none

module acked_record_send_window_top
  import arsw_pkg::*;
#(
  parameter int unsigned INDEX_BITS  = ARSW_INDEX_BITS,
  parameter int unsigned RECORD_BITS = ARSW_RECORD_BITS
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [63:0] record_data, [73:64] ack_value, [79:74] zero
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] op
  input  wire logic [OP_W-1:0]      s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [9:0] start_index, [14:10] batch_count, [78:15] record_out, [79] zero
  output logic [M_TDATA_W-1:0]      m_axis_tdata_o,
  // [0] item_kind
  output logic                      m_axis_tuser_o,
  output logic                      m_axis_tlast_o,
  input  wire logic                 cfg_wvalid_i,
  output logic                      cfg_wready_o,
  input  wire logic [CNT_W-1:0]     cfg_wdata_i
);

  arsw_cmd_t cmd;
  arsw_sts_t sts;

  logic                   ram_we;
  logic [INDEX_BITS-1:0]  ram_waddr;
  logic [RECORD_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [INDEX_BITS-1:0]  ram_raddr;
  logic [RECORD_BITS-1:0] ram_rdata;

  assign cfg_wready_o = 1'b1;

  arsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .op_i       (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arsw_datapath #(
    .INDEX_BITS  (INDEX_BITS),
    .RECORD_BITS (RECORD_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .op_i          (s_axis_tuser_i),
    .record_data_i (s_axis_tdata_i[DATA_W-1:0]),
    .ack_value_i   (s_axis_tdata_i[DATA_W+ACK_W-1:DATA_W]),
    .cfg_we_i      (cfg_wvalid_i),
    .cfg_data_i    (cfg_wdata_i),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .m_tready_i    (m_axis_tready_i),
    .m_tvalid_o    (m_axis_tvalid_o),
    .m_tdata_o     (m_axis_tdata_o),
    .m_tuser_o     (m_axis_tuser_o),
    .m_tlast_o     (m_axis_tlast_o)
  );

  arsw_ram #(
    .WIDTH (RECORD_BITS),
    .DEPTH (2 ** INDEX_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire

/* sv/arsw_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module arsw_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* sv/arsw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module arsw_ctrl
  import arsw_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [OP_W-1:0] op_i,
  output logic                 in_ready_o,
  input  wire arsw_sts_t       sts_i,
  output arsw_cmd_t            cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_REC
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i;
        if (in_valid_i && (op_i == OP_SEND) && sts_i.send_nonempty) begin
          state_d = ST_HDR;
        end
      end
      ST_HDR: begin
        if (sts_i.out_free) begin
          cmd_o.load_hdr = 1'b1;
          state_d        = ST_REC;
        end
      end
      ST_REC: begin
        if (sts_i.out_free) begin
          cmd_o.load_rec = 1'b1;
          if (sts_i.rec_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* sv/arsw_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module arsw_datapath
  import arsw_pkg::*;
#(
  parameter int unsigned INDEX_BITS  = ARSW_INDEX_BITS,
  parameter int unsigned RECORD_BITS = ARSW_RECORD_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire arsw_cmd_t              cmd_i,
  output arsw_sts_t                   sts_o,
  input  wire logic [OP_W-1:0]        op_i,
  input  wire logic [DATA_W-1:0]      record_data_i,
  input  wire logic [ACK_W-1:0]       ack_value_i,
  input  wire logic                   cfg_we_i,
  input  wire logic [CNT_W-1:0]       cfg_data_i,
  // record store port
  output logic                        ram_we_o,
  output logic [INDEX_BITS-1:0]       ram_waddr_o,
  output logic [RECORD_BITS-1:0]      ram_wdata_o,
  output logic                        ram_re_o,
  output logic [INDEX_BITS-1:0]       ram_raddr_o,
  input  wire logic [RECORD_BITS-1:0] ram_rdata_i,
  // result stream
  input  wire logic                   m_tready_i,
  output logic                        m_tvalid_o,
  output logic [M_TDATA_W-1:0]        m_tdata_o,
  output logic                        m_tuser_o,
  output logic                        m_tlast_o
);

  localparam int unsigned IW = INDEX_BITS;

  logic [IW-1:0]    ack_q, ack_d;
  logic [IW-1:0]    snd_q, snd_d;
  logic [IW-1:0]    wr_q, wr_d;
  logic [CNT_W-1:0] blim_q;
  logic [IW-1:0]    start_q;
  logic [CNT_W-1:0] num_q;
  logic [CNT_W-1:0] cnt_q;

  logic             out_valid_q;
  logic             out_kind_q;
  logic [START_W-1:0] out_start_q;
  logic [CNT_W-1:0] out_num_q;
  logic [DATA_W-1:0] out_rec_q;
  logic             out_last_q;

  // batch size for a send request at the current pointers
  logic [CNT_W-1:0] lim;
  logic [IW:0]      to_end;
  logic [IW:0]      avail;
  logic [CNT_W-1:0] num;

  always_comb begin
    if (blim_q == '0) begin
      lim = CNT_W'(1);
    end else if (blim_q > MAX_BATCH) begin
      lim = MAX_BATCH;
    end else begin
      lim = blim_q;
    end
    to_end = {1'b0, ~snd_q} + (IW+1)'(1);
    if (snd_q > wr_q) begin
      avail = to_end;
    end else begin
      avail = {1'b0, wr_q - snd_q};
    end
    if (avail > (IW+1)'(lim)) begin
      num = lim;
    end else begin
      num = avail[CNT_W-1:0];
    end
  end

  // ack index: low ten bits, then reduced to the ring
  logic [IW+ACK_W-1:0] ack_ext;
  logic [IW-1:0]       ack_idx;
  logic [IW-1:0]       sent_span;
  logic [IW-1:0]       ack_dist;
  logic [IW-1:0]       ack_inc;

  assign ack_ext   = {{IW{1'b0}}, ack_value_i};
  assign ack_idx   = ack_ext[IW-1:0];
  assign sent_span = snd_q - IW'(1) - ack_q;
  assign ack_dist  = ack_idx - ack_q;
  assign ack_inc   = ack_q + IW'(1);

  always_comb begin
    ack_d = ack_q;
    snd_d = snd_q;
    wr_d  = wr_q;
    if (cmd_i.take) begin
      case (op_i)
        OP_INSERT: begin
          if (wr_q == ack_q) begin
            // ring full: drop the oldest entry
            ack_d = ack_inc;
            if (ack_inc == snd_q) begin
              snd_d = snd_q + IW'(1);
            end
          end
          wr_d = wr_q + IW'(1);
        end
        OP_SEND: begin
          snd_d = snd_q + IW'(num);
        end
        OP_ACK: begin
          if (ack_dist <= sent_span) begin
            ack_d = ack_idx;
          end
        end
        OP_REWIND: begin
          snd_d = ack_inc;
        end
        default: ;
      endcase
    end
  end

  logic out_free;
  logic rec_last;

  assign out_free = !out_valid_q || m_tready_i;
  assign rec_last = (cnt_q + CNT_W'(1)) == num_q;

  assign sts_o.send_nonempty = (snd_q != wr_q);
  assign sts_o.out_free      = out_free;
  assign sts_o.rec_last      = rec_last;

  // store access: record i is fetched one step ahead of its output load
  assign ram_we_o    = cmd_i.take && (op_i == OP_INSERT);
  assign ram_waddr_o = wr_q;
  assign ram_wdata_o = record_data_i[RECORD_BITS-1:0];
  assign ram_re_o    = (cmd_i.take && (op_i == OP_SEND)) || cmd_i.load_rec;
  assign ram_raddr_o = cmd_i.take ? snd_q : (start_q + IW'(cnt_q) + IW'(1));

  logic [IW+START_W-1:0]      start_ext;
  logic [RECORD_BITS+DATA_W-1:0] rec_ext;

  assign start_ext = {{START_W{1'b0}}, start_q};
  assign rec_ext   = {{DATA_W{1'b0}}, ram_rdata_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_q       <= '0;
      snd_q       <= IW'(1);
      wr_q        <= IW'(1);
      blim_q      <= BLIM_RESET;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      ack_q <= ack_d;
      snd_q <= snd_d;
      wr_q  <= wr_d;
      if (cfg_we_i) begin
        blim_q <= cfg_data_i;
      end
      if (cmd_i.load_hdr) begin
        cnt_q <= '0;
      end else if (cmd_i.load_rec) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.load_hdr || cmd_i.load_rec) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && (op_i == OP_SEND)) begin
      start_q <= snd_q;
      num_q   <= num;
    end
    if (cmd_i.load_hdr) begin
      out_kind_q  <= KIND_HEADER;
      out_start_q <= start_ext[START_W-1:0];
      out_num_q   <= num_q;
      out_rec_q   <= '0;
      out_last_q  <= 1'b0;
    end else if (cmd_i.load_rec) begin
      out_kind_q  <= KIND_RECORD;
      out_rec_q   <= rec_ext[DATA_W-1:0];
      out_last_q  <= rec_last;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {1'b0, out_rec_q, out_num_q, out_start_q};

  `include "acked_record_send_window_top_macros.svh"

  `ARSW_ASSERT(a_load_when_free, (!(cmd_i.load_hdr || cmd_i.load_rec)) || out_free, "output register overwritten while still held")
  `ARSW_ASSERT(a_rec_in_batch, (!cmd_i.load_rec) || ((num_q != '0) && (num_q <= MAX_BATCH) && (cnt_q < num_q)), "record load outside batch bounds")
  `ARSW_ASSERT_NEXT(a_last_ends_batch, cmd_i.load_rec && rec_last, !cmd_i.load_rec, "record load after last record of batch")
  `ARSW_ASSERT_NEXT(a_hdr_then_valid, cmd_i.load_hdr, out_valid_q && (out_kind_q == KIND_HEADER), "header load did not reach output")

endmodule

`default_nettype wire
